/* rtl/vdu_pkg.sv */
// Shared types and constants of the vector distance unit.
package vdu_pkg;

  localparam int unsigned MAX_DIM_DEF    = 1024;
  localparam int unsigned ELEM_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned DIST_W     = 42;
  localparam int unsigned DIST_BYTES = (DIST_W + 7) / 8;
  localparam int unsigned OUT_TDATA_W = DIST_BYTES * 8;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    METRIC_SQ_EUCLID  = 2'd0,
    METRIC_EUCLID     = 2'd1,
    METRIC_MANHATTAN  = 2'd2,
    METRIC_CHEBYSHEV  = 2'd3
  } metric_e;

endpackage

/* rtl/vector_distance_unit.sv */
// Top level of the vector distance unit: configuration register, front end, queue and back end.
// Takes one element pair per cycle while the result register is free and no square root runs.
// The final pair passes the queue and then the result register; in Euclidean mode the
// bit-serial square root runs in between and holds the back end meanwhile.
// Reset clears accumulator, element count, clip flag, queue, result valid; metric goes to 0.
module vector_distance_unit #(
  parameter int unsigned MAX_DIM    = vdu_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = vdu_pkg::ELEM_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // x_elem, y_elem
  input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // distance
  output logic [vdu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // saturated
  output logic                              m_axis_tuser
);

  localparam int unsigned AD_W    = ELEM_WIDTH + 1;
  localparam int unsigned SQ_FULL = 2 * AD_W;
  localparam int unsigned TERM_W  = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int unsigned ENTRY_W = TERM_W + 3;

  vdu_pkg::metric_e    metric_q;
  logic                q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0]  q_wdata, q_rdata;
  logic [vdu_pkg::DIST_W-1:0] result_dist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vdu_pkg::METRIC_SQ_EUCLID;
    end else if (cfg_we_i) begin
      metric_q <= vdu_pkg::metric_e'(cfg_wdata_i);
    end
  end

  vdu_front #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .TERM_W     (TERM_W)
  ) u_front (
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .x_i      (s_axis_tdata[ELEM_WIDTH-1:0]),
    .y_i      (s_axis_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
    .last_i   (s_axis_tlast),
    .metric_i (metric_q),
    .full_i   (q_full),
    .push_o   (q_push),
    .entry_o  (q_wdata)
  );

  vdu_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (vdu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vdu_back #(
    .MAX_DIM (MAX_DIM),
    .TERM_W  (TERM_W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .entry_i (q_rdata),
    .pop_o   (q_pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .dist_o  (result_dist),
    .sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = vdu_pkg::OUT_TDATA_W'(result_dist);

endmodule

/* rtl/vdu_front.sv */
// Front end: accepts element pairs, forms the per-element term and tags it with the metric.
module vdu_front #(
  parameter int unsigned ELEM_WIDTH = vdu_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned TERM_W     = 2 * ELEM_WIDTH + 2
) (
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [ELEM_WIDTH-1:0] x_i,
  input  logic signed [ELEM_WIDTH-1:0] y_i,
  input  logic                         last_i,
  input  vdu_pkg::metric_e             metric_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [TERM_W+2:0]            entry_o
);

  localparam int unsigned AD_W = ELEM_WIDTH + 1;

  logic [AD_W-1:0]   diff;
  logic [AD_W-1:0]   abs_diff;
  logic [TERM_W-1:0] square;
  logic [TERM_W-1:0] term;

  assign diff     = {x_i[ELEM_WIDTH-1], x_i} - {y_i[ELEM_WIDTH-1], y_i};
  assign abs_diff = diff[AD_W-1] ? (~diff + AD_W'(1)) : diff;
  assign square   = TERM_W'(abs_diff) * TERM_W'(abs_diff);

  always_comb begin
    case (metric_i)
      vdu_pkg::METRIC_SQ_EUCLID, vdu_pkg::METRIC_EUCLID: term = square;
      default: term = TERM_W'(abs_diff);
    endcase
  end

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign entry_o = {last_i, metric_i, term};

endmodule

/* rtl/vdu_queue.sv */
// Short first-in first-out queue between the front and back ends.
module vdu_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = vdu_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/vdu_isqrt.sv */
// Bit-serial integer square root, rounded down, two radicand bits per cycle.
module vdu_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vdu_pkg::DIST_W-1:0]   radicand_i,
  output logic                         busy_o,
  output logic [vdu_pkg::DIST_W/2-1:0] root_o
);

  localparam int unsigned RAD_W  = vdu_pkg::DIST_W;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned STEP_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [ROOT_W+2:0] rem_shift;
  logic [ROOT_W+2:0] trial;
  logic              fits;

  assign rem_shift = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(ROOT_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? (ROOT_W+1)'(rem_shift - trial) : (ROOT_W+1)'(rem_shift);
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* rtl/vdu_back.sv */
// Back end: accumulates terms, applies the metric at the end of a vector and holds the result.
module vdu_back #(
  parameter int unsigned MAX_DIM = vdu_pkg::MAX_DIM_DEF,
  parameter int unsigned TERM_W  = 34
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  logic [TERM_W+2:0]          entry_i,
  output logic                       pop_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [vdu_pkg::DIST_W-1:0] dist_o,
  output logic                       sat_o
);

  localparam int unsigned DIST_W = vdu_pkg::DIST_W;
  localparam int unsigned SUM_W  = ((TERM_W > DIST_W) ? TERM_W : DIST_W) + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIM + 1);
  localparam logic        ST_RUN  = 1'b0;
  localparam logic        ST_SQRT = 1'b1;

  logic [TERM_W-1:0]      term;
  vdu_pkg::metric_e       metric;
  logic                   last;
  logic                   st_q, st_d;
  logic [DIST_W-1:0]      acc_q, acc_d, acc_next;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   clip_q, clip_d, clip_next;
  logic                   pend_sat_q, pend_sat_d;
  logic                   out_valid_q, out_valid_d;
  logic [DIST_W-1:0]      out_dist_q, out_dist_d;
  logic                   out_sat_q, out_sat_d;
  logic                   out_free, at_limit;
  logic [SUM_W-1:0]       cand;
  logic                   sqrt_start, sqrt_busy;
  logic [DIST_W/2-1:0]    sqrt_root;

  assign term   = entry_i[TERM_W-1:0];
  assign metric = vdu_pkg::metric_e'(entry_i[TERM_W+1:TERM_W]);
  assign last   = entry_i[TERM_W+2];

  assign out_free = !out_valid_q || ready_i;
  assign at_limit = (cnt_q == CNT_W'(MAX_DIM));
  assign pop_o    = !empty_i && (st_q == ST_RUN) && (!last || out_free);

  always_comb begin
    case (metric)
      vdu_pkg::METRIC_CHEBYSHEV: begin
        cand = (SUM_W'(term) > SUM_W'(acc_q)) ? SUM_W'(term) : SUM_W'(acc_q);
      end
      default: cand = SUM_W'(acc_q) + SUM_W'(term);
    endcase
    acc_next  = acc_q;
    clip_next = clip_q;
    if (at_limit) begin
      clip_next = 1'b1;
    end else if (cand > SUM_W'(vdu_pkg::DIST_MAX)) begin
      acc_next  = vdu_pkg::DIST_MAX;
      clip_next = 1'b1;
    end else begin
      acc_next = DIST_W'(cand);
    end
  end

  always_comb begin
    st_d        = st_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    clip_d      = clip_q;
    pend_sat_d  = pend_sat_q;
    out_valid_d = out_valid_q && !ready_i;
    out_dist_d  = out_dist_q;
    out_sat_d   = out_sat_q;
    sqrt_start  = 1'b0;
    if (pop_o) begin
      if (last) begin
        acc_d  = '0;
        cnt_d  = '0;
        clip_d = 1'b0;
        if (metric == vdu_pkg::METRIC_EUCLID) begin
          sqrt_start = 1'b1;
          pend_sat_d = clip_next;
          st_d       = ST_SQRT;
        end else begin
          out_valid_d = 1'b1;
          out_dist_d  = acc_next;
          out_sat_d   = clip_next;
        end
      end else begin
        acc_d  = acc_next;
        clip_d = clip_next;
        if (!at_limit) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
    if ((st_q == ST_SQRT) && !sqrt_busy && out_free) begin
      out_valid_d = 1'b1;
      out_dist_d  = DIST_W'(sqrt_root);
      out_sat_d   = pend_sat_q;
      st_d        = ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      acc_q       <= '0;
      cnt_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sat_q <= pend_sat_d;
    out_dist_q <= out_dist_d;
    out_sat_q  <= out_sat_d;
  end

  vdu_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_next),
    .busy_o     (sqrt_busy),
    .root_o     (sqrt_root)
  );

  assign valid_o = out_valid_q;
  assign dist_o  = out_dist_q;
  assign sat_o   = out_sat_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DIM))
    else $error("element count beyond the maximum dimension");
  a_no_pop_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SQRT) |-> !pop_o)
    else $error("queue popped while the square root is pending");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && last) |=> (cnt_q == '0 && acc_q == '0 && !clip_q))
    else $error("accumulator not cleared after the final pair");
  a_sqrt_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench of the vector distance unit, with a built-in distance predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PERCENT  = 38;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [vdu_pkg::DIST_W-1:0] distance;
    logic                       saturated;
  } distance_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [1:0]                      cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [vdu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  distance_result_t    expected_distances[$];
  vdu_pkg::metric_e    active_metric;
  longint unsigned     acc_sum;
  int unsigned         pair_count;
  bit                  clipped;
  int unsigned         error_count;
  bit                  no_gaps;
  bit                  hold_request;

  vector_distance_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("vector_distance_unit: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  task automatic fold_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic last);
    longint signed    diff;
    longint unsigned  mag;
    longint unsigned  sum;
    longint unsigned  dist_value;
    distance_result_t result;
    diff = longint'(x) - longint'(y);
    mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
    if (pair_count >= vdu_pkg::MAX_DIM_DEF) begin
      clipped = 1'b1;
    end else begin
      pair_count++;
      case (active_metric)
        vdu_pkg::METRIC_SQ_EUCLID, vdu_pkg::METRIC_EUCLID: sum = acc_sum + mag * mag;
        vdu_pkg::METRIC_MANHATTAN:                         sum = acc_sum + mag;
        default:                                           sum = (mag > acc_sum) ? mag : acc_sum;
      endcase
      if (sum > 64'(vdu_pkg::DIST_MAX)) begin
        sum     = 64'(vdu_pkg::DIST_MAX);
        clipped = 1'b1;
      end
      acc_sum = sum;
    end
    if (last) begin
      dist_value = (active_metric == vdu_pkg::METRIC_EUCLID) ? floor_sqrt(acc_sum) : acc_sum;
      result.distance  = vdu_pkg::DIST_W'(dist_value);
      result.saturated = clipped;
      expected_distances.push_back(result);
      acc_sum    = 0;
      pair_count = 0;
      clipped    = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        active_metric = vdu_pkg::metric_e'(cfg_wdata_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fold_pair(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
      end
    end
  end

  initial begin
    distance_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_distances.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %h", m_axis_tdata));
        end else begin
          want = expected_distances.pop_front();
          if (m_axis_tdata !==
              {{(vdu_pkg::OUT_TDATA_W-vdu_pkg::DIST_W){1'b0}}, want.distance}) begin
            report_mismatch($sformatf("distance %h, predicted %h", m_axis_tdata,
                                      want.distance));
          end
          if (m_axis_tuser !== want.saturated) begin
            report_mismatch($sformatf("saturated %b, predicted %b", m_axis_tuser,
                                      want.saturated));
          end
        end
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (no_gaps) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) begin
      send_pair(pick_elem(), pick_elem(), i == len);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_distances.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_metric(input vdu_pkg::metric_e m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_extreme_elements();
    for (int m = 0; m < 4; m++) begin
      write_metric(vdu_pkg::metric_e'(m));
      send_pair(16'h7fff, 16'h8000, 1'b0);
      send_pair(16'h8000, 16'h7fff, 1'b0);
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'hffff, 16'h0001, 1'b1);
    end
  endtask

  task automatic test_metric_change_mid_vector();
    write_metric(vdu_pkg::METRIC_MANHATTAN);
    send_pair(16'd100, -16'sd300, 1'b0);
    write_metric(vdu_pkg::METRIC_SQ_EUCLID);
    send_pair(-16'sd5, 16'd7, 1'b0);
    write_metric(vdu_pkg::METRIC_CHEBYSHEV);
    send_pair(16'd1000, -16'sd1000, 1'b0);
    write_metric(vdu_pkg::METRIC_EUCLID);
    send_pair(16'd3, 16'd4, 1'b1);
  endtask

  task automatic test_overlong_vector();
    write_metric(vdu_pkg::METRIC_EUCLID);
    send_vector(vdu_pkg::MAX_DIM_DEF + 2);
  endtask

  task automatic test_output_backpressure();
    write_metric(vdu_pkg::METRIC_EUCLID);
    hold_request = 1'b1;
    repeat (40) send_pair(pick_elem(), pick_elem(), 1'b1);
    write_metric(vdu_pkg::METRIC_MANHATTAN);
    hold_request = 1'b1;
    repeat (40) send_vector($urandom_range(1, 2));
  endtask

  task automatic test_random_vectors();
    int unsigned sent;
    int unsigned phase_items;
    int unsigned len;
    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      write_metric(p < 4 ? vdu_pkg::metric_e'(p) : vdu_pkg::metric_e'($urandom_range(0, 3)));
      no_gaps     = (p == 2);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_vector(len);
        phase_items += len;
      end
      sent += phase_items;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    active_metric = vdu_pkg::METRIC_SQ_EUCLID;
    acc_sum       = 0;
    pair_count    = 0;
    clipped       = 1'b0;
    error_count   = 0;
    no_gaps       = 1'b0;
    hold_request  = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= vdu_pkg::METRIC_SQ_EUCLID;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_elements();
    test_metric_change_mid_vector();
    test_overlong_vector();
    test_output_backpressure();
    test_random_vectors();
    wait_drained();

    if (error_count == 0) begin
      $display("vector_distance_unit: match");
    end else begin
      $display("vector_distance_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/vdu_pkg.sv
rtl/vdu_front.sv
rtl/vdu_queue.sv
rtl/vdu_isqrt.sv
rtl/vdu_back.sv
rtl/vector_distance_unit.sv
test/testbench.sv
